### rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and arithmetic helpers for the barometric pressure
// compensation core.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int DIV_BITS = 32;

    localparam logic [31:0] TF_OFFSET  = 32'd64000;
    localparam logic [31:0] DIV_BIAS   = 32'd32768;
    localparam logic [31:0] ADC_FULL   = 32'd1048576;
    localparam logic [31:0] PRESS_GAIN = 32'd3125;
    localparam logic [31:0] TOP_BIT    = 32'h8000_0000;

    typedef enum logic [1:0] {
        REG_TEMP_COEFFS  = 2'd0,
        REG_PRESS_LOW    = 2'd1,
        REG_PRESS_HIGH   = 2'd2,
        REG_PRESS_NINE   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [19:0] adc_pressure;
        logic [19:0] adc_temperature;
    } sample_t;

    typedef struct packed {
        logic [31:0] pressure_pa;
        logic        divisor_zero;
    } result_t;

    // low 32 bits of a product
    function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
        logic [63:0] full;
        full = a * b;
        return full[31:0];
    endfunction

    // arithmetic right shift of a two's complement pattern
    function automatic logic [31:0] asr(logic [31:0] x, logic [4:0] s);
        return 32'($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

### rtl/barometric_pressure_compensation_core.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core
// Converts raw pressure/temperature readings to compensated pressure in Pa.
// ----------------------------------------------------------------------------
// One sample pair is taken in every clock cycle (busy never rises) and its
// result appears on result with done high after 13 arithmetic stages and
// the 32-step restoring divider, which yields one quotient bit per stage.
// Results cannot be held off; each done pulse lasts one cycle. Coefficient
// registers may be written only while no sample is in flight.
module barometric_pressure_compensation_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bpc_pkg::sample_t  sample,
    output logic              done,
    output bpc_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data
);

    // edges from the accepting edge to the edge that takes the result
    localparam int LAT = bpc_pkg::DIV_BITS + 14;
    localparam int DB  = bpc_pkg::DIV_BITS;

    // ------------------------------------------------------------------
    // coefficient registers
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (bpc_pkg::cfg_reg_t'(cfg_index))
                bpc_pkg::REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                bpc_pkg::REG_PRESS_LOW:   press_low_reg   <= cfg_data;
                bpc_pkg::REG_PRESS_HIGH:  press_high_reg  <= cfg_data;
                bpc_pkg::REG_PRESS_NINE:  press_nine_reg  <= cfg_data[15:0];
                default:                  press_nine_reg  <= press_nine_reg;
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'b0, temp_coeffs_reg[15:0]};
    assign t2 = bpc_pkg::sx16(temp_coeffs_reg[31:16]);
    assign t3 = bpc_pkg::sx16(temp_coeffs_reg[47:32]);
    assign p1 = {16'b0, press_low_reg[15:0]};
    assign p2 = bpc_pkg::sx16(press_low_reg[31:16]);
    assign p3 = bpc_pkg::sx16(press_low_reg[47:32]);
    assign p4 = bpc_pkg::sx16(press_low_reg[63:48]);
    assign p5 = bpc_pkg::sx16(press_high_reg[15:0]);
    assign p6 = bpc_pkg::sx16(press_high_reg[31:16]);
    assign p7 = bpc_pkg::sx16(press_high_reg[47:32]);
    assign p8 = bpc_pkg::sx16(press_high_reg[63:48]);
    assign p9 = bpc_pkg::sx16(press_nine_reg);

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // valid chain for the arithmetic front end (stage 0 .. 9)
    logic [9:0]  v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[8:0], start & ~busy};
    end

    // stage 0: capture
    logic [31:0] ap0_reg, at0_reg;
    // stage 1..9 payload
    logic [31:0] ap1_reg, m1_reg, dd_reg;
    logic [31:0] ap2_reg, a2_reg, b2_reg;
    logic [31:0] ap3_reg, pa3_reg, q3_reg;
    logic [31:0] ap4_reg, sq4_reg, m5_reg, m2_reg;
    logic [31:0] ap5_reg, m5b_reg, m2b_reg, b1_reg, m3_reg;
    logic [31:0] ap6_reg, b6_reg, a6_reg;
    logic [31:0] ap7_reg, b7_reg, a7_reg;
    logic [31:0] num8_reg, dv8_reg;
    logic [31:0] pm9_reg, dv9_reg;

    logic [31:0] d1;
    logic [31:0] tf3, pa3;
    logic [31:0] b6;

    assign d1  = (at0_reg >> 4) - t1;
    assign tf3 = a2_reg + bpc_pkg::asr(b2_reg, 5'd14);
    assign pa3 = bpc_pkg::asr(tf3, 5'd1) - bpc_pkg::TF_OFFSET;
    assign b6  = bpc_pkg::asr(b1_reg + (m5b_reg << 1), 5'd2) + (p4 << 16);

    always_ff @(posedge clk)
    begin
        ap0_reg  <= {12'b0, sample.adc_pressure};
        at0_reg  <= {12'b0, sample.adc_temperature};

        ap1_reg  <= ap0_reg;
        m1_reg   <= bpc_pkg::mul32((at0_reg >> 3) - (t1 << 1), t2);
        dd_reg   <= bpc_pkg::mul32(d1, d1);

        ap2_reg  <= ap1_reg;
        a2_reg   <= bpc_pkg::asr(m1_reg, 5'd11);
        b2_reg   <= bpc_pkg::mul32(bpc_pkg::asr(dd_reg, 5'd12), t3);

        ap3_reg  <= ap2_reg;
        pa3_reg  <= pa3;
        q3_reg   <= bpc_pkg::asr(pa3, 5'd2);

        ap4_reg  <= ap3_reg;
        sq4_reg  <= bpc_pkg::mul32(q3_reg, q3_reg);
        m5_reg   <= bpc_pkg::mul32(pa3_reg, p5);
        m2_reg   <= bpc_pkg::mul32(p2, pa3_reg);

        ap5_reg  <= ap4_reg;
        m5b_reg  <= m5_reg;
        m2b_reg  <= m2_reg;
        b1_reg   <= bpc_pkg::mul32(bpc_pkg::asr(sq4_reg, 5'd11), p6);
        m3_reg   <= bpc_pkg::mul32(p3, bpc_pkg::asr(sq4_reg, 5'd13));

        ap6_reg  <= ap5_reg;
        b6_reg   <= b6;
        a6_reg   <= bpc_pkg::asr(bpc_pkg::asr(m3_reg, 5'd3)
                                 + bpc_pkg::asr(m2b_reg, 5'd1), 5'd18);

        ap7_reg  <= ap6_reg;
        b7_reg   <= b6_reg;
        a7_reg   <= bpc_pkg::mul32(bpc_pkg::DIV_BIAS + a6_reg, p1);

        num8_reg <= (bpc_pkg::ADC_FULL - ap7_reg) - bpc_pkg::asr(b7_reg, 5'd12);
        dv8_reg  <= bpc_pkg::asr(a7_reg, 5'd15);

        pm9_reg  <= bpc_pkg::mul32(num8_reg, bpc_pkg::PRESS_GAIN);
        dv9_reg  <= dv8_reg;
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage
    logic [DB:0] dv_v_reg;
    logic [31:0] rem_reg [0:DB];
    logic [31:0] dvd_reg [0:DB];
    logic [31:0] quo_reg [0:DB];
    logic [31:0] dvs_reg [0:DB];
    logic        dbl_reg [0:DB];
    logic        zero_reg [0:DB];
    logic [32:0] trial [0:DB-1];
    logic [DB-1:0] fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg <= '0;
        else
            dv_v_reg <= {dv_v_reg[DB-1:0], v_reg[9]};
    end

    always_comb
    begin
        for (int k = 0; k < DB; k++)
        begin
            trial[k] = {rem_reg[k], dvd_reg[k][31]};
            fits[k]  = (trial[k] >= {1'b0, dvs_reg[k]});
        end
    end

    // pick dividend by the top-bit test; with the top bit set the doubling follows the divide, else it precedes it
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        quo_reg[0]  <= '0;
        dvs_reg[0]  <= dv9_reg;
        dbl_reg[0]  <= (pm9_reg >= bpc_pkg::TOP_BIT);
        dvd_reg[0]  <= (pm9_reg >= bpc_pkg::TOP_BIT) ? pm9_reg : (pm9_reg << 1);
        zero_reg[0] <= (dv9_reg == '0);
        for (int k = 0; k < DB; k++)
        begin
            rem_reg[k+1]  <= fits[k] ? 32'(trial[k] - {1'b0, dvs_reg[k]})
                                     : trial[k][31:0];
            quo_reg[k+1]  <= {quo_reg[k][30:0], fits[k]};
            dvd_reg[k+1]  <= dvd_reg[k] << 1;
            dvs_reg[k+1]  <= dvs_reg[k];
            dbl_reg[k+1]  <= dbl_reg[k];
            zero_reg[k+1] <= zero_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // final correction
    logic [1:0]  pv_reg;
    logic [31:0] pq, r_q;
    logic [31:0] pp1_reg, rr1_reg, m81_reg;
    logic        z1_reg;
    logic [31:0] pp2_reg, a2c_reg, b2c_reg;
    logic        z2_reg;
    logic        done_reg;
    bpc_pkg::result_t result_reg;
    bpc_pkg::result_t result_next;

    assign pq  = dbl_reg[DB] ? (quo_reg[DB] << 1) : quo_reg[DB];
    assign r_q = pq >> 3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pv_reg   <= {pv_reg[0], dv_v_reg[DB]};
            done_reg <= pv_reg[1];
        end
    end

    always_comb
    begin
        if (z2_reg)
        begin
            result_next.pressure_pa  = '0;
            result_next.divisor_zero = 1'b1;
        end
        else
        begin
            result_next.pressure_pa  = pp2_reg
                + bpc_pkg::asr(a2c_reg + b2c_reg + p7, 5'd4);
            result_next.divisor_zero = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pp1_reg    <= pq;
        rr1_reg    <= bpc_pkg::mul32(r_q, r_q);
        m81_reg    <= bpc_pkg::mul32(pq >> 2, p8);
        z1_reg     <= zero_reg[DB];

        pp2_reg    <= pp1_reg;
        a2c_reg    <= bpc_pkg::asr(bpc_pkg::mul32(p9, rr1_reg >> 13), 5'd12);
        b2c_reg    <= bpc_pkg::asr(m81_reg, 5'd13);
        z2_reg     <= z1_reg;

        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("accepted sample produced no result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a sample");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.divisor_zero |-> result.pressure_pa == '0)
        else $error("zero divisor with nonzero pressure");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v_reg[DB] && !zero_reg[DB] |-> rem_reg[DB] < dvs_reg[DB])
        else $error("divider remainder out of range");

endmodule

### tb/barometric_pressure_compensation_checker.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_checker
// Watches the sample, result and coefficient channels of the core, predicts
// the compensated pressure for every accepted sample and compares results.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  bpc_pkg::sample_t  sample,
    input  logic              done,
    input  bpc_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [47:0] temp_c;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] press_p9;
    bpc_pkg::result_t expected_q[$];

    function automatic logic [31:0] prod32(logic [31:0] a, logic [31:0] b);
        logic [63:0] f;
        f = {32'd0, a} * {32'd0, b};
        return f[31:0];
    endfunction

    function automatic logic [31:0] sra(logic [31:0] x, int s);
        logic signed [31:0] v;
        v = x;
        return v >>> s;
    endfunction

    function automatic logic [31:0] ext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic bpc_pkg::result_t compensate(bpc_pkg::sample_t s);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] ap, at, a, b, d, q, sq, tf, p, r;
        bpc_pkg::result_t res;
        t1 = {16'd0, temp_c[15:0]};
        t2 = ext16(temp_c[31:16]);
        t3 = ext16(temp_c[47:32]);
        p1 = {16'd0, press_lo[15:0]};
        p2 = ext16(press_lo[31:16]);
        p3 = ext16(press_lo[47:32]);
        p4 = ext16(press_lo[63:48]);
        p5 = ext16(press_hi[15:0]);
        p6 = ext16(press_hi[31:16]);
        p7 = ext16(press_hi[47:32]);
        p8 = ext16(press_hi[63:48]);
        p9 = ext16(press_p9);
        ap = {12'd0, s.adc_pressure};
        at = {12'd0, s.adc_temperature};
        a = sra(prod32((at >> 3) - (t1 << 1), t2), 11);
        d = (at >> 4) - t1;
        b = sra(prod32(sra(prod32(d, d), 12), t3), 14);
        tf = a + b;
        a = sra(tf, 1) - 32'd64000;
        q = sra(a, 2);
        sq = prod32(q, q);
        b = prod32(sra(sq, 11), p6);
        b = b + (prod32(a, p5) << 1);
        b = sra(b, 2) + (p4 << 16);
        a = sra(sra(prod32(p3, sra(sq, 13)), 3) + sra(prod32(p2, a), 1), 18);
        a = sra(prod32(32'd32768 + a, p1), 15);
        if (a == 32'd0)
        begin
            res.pressure_pa = '0;
            res.divisor_zero = 1'b1;
            return res;
        end
        p = prod32((32'd1048576 - ap) - sra(b, 12), 32'd3125);
        if (p < 32'h8000_0000)
            p = (p << 1) / a;
        else
            p = (p / a) * 32'd2;
        r = p >> 3;
        a = sra(prod32(p9, prod32(r, r) >> 13), 12);
        b = sra(prod32(p >> 2, p8), 13);
        p = p + sra(a + b + p7, 4);
        res.pressure_pa = p;
        res.divisor_zero = 1'b0;
        return res;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        bpc_pkg::result_t want;
        int errs;
        if (!rst_n)
        begin
            temp_c   <= '0;
            press_lo <= '0;
            press_hi <= '0;
            press_p9 <= '0;
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            errs = 0;
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat: actual %h", $time, result);
                    errs++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.pressure_pa !== result.pressure_pa)
                    begin
                        $display("%0t: pressure_pa expected %h actual %h",
                                 $time, want.pressure_pa, result.pressure_pa);
                        errs++;
                    end
                    if (want.divisor_zero !== result.divisor_zero)
                    begin
                        $display("%0t: divisor_zero expected %b actual %b",
                                 $time, want.divisor_zero, result.divisor_zero);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            // predict with coefficients in force before this edge's write
            if (start && !busy)
                expected_q.push_back(compensate(sample));
            if (cfg_we)
            begin
                case (bpc_pkg::cfg_reg_t'(cfg_index))
                    bpc_pkg::REG_TEMP_COEFFS: temp_c   <= cfg_data[47:0];
                    bpc_pkg::REG_PRESS_LOW:   press_lo <= cfg_data;
                    bpc_pkg::REG_PRESS_HIGH:  press_hi <= cfg_data;
                    bpc_pkg::REG_PRESS_NINE:  press_p9 <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/barometric_pressure_compensation_core_tb.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core_tb
// Drives samples and coefficient sets into the compensation core with random
// gaps; the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY  = 45;
    localparam int WDOG_MAX = 4000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    bpc_pkg::sample_t sample;
    logic             done;
    bpc_pkg::result_t result;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [63:0]      cfg_data;
    int               fail_count;
    int               pending;
    int               idle_cycles;
    int               sent;
    int               phases;

    barometric_pressure_compensation_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    barometric_pressure_compensation_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: count cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // caller drops cfg_we after the last write of a set
    task automatic put_coeff(bpc_pkg::cfg_reg_t idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_beat(logic [19:0] ap, logic [19:0] at, int gap);
        start  <= 1'b1;
        sample <= '{adc_pressure: ap, adc_temperature: at};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // typical sensor calibration, perturbed when jitter is set
    task automatic load_typical(bit jitter);
        logic [15:0] t[3];
        logic [15:0] p[9];
        t = '{16'd27504, 16'd26435, 16'hFC18};
        p = '{16'd36477, 16'hD573, 16'd3024, 16'd2855, 16'd140,
              16'hFFF9, 16'd15500, 16'hD80C, 16'd6000};
        if (jitter)
        begin
            foreach (t[i]) t[i] = t[i] + 16'($urandom_range(0, 400)) - 16'd200;
            foreach (p[i]) p[i] = p[i] + 16'($urandom_range(0, 400)) - 16'd200;
        end
        put_coeff(bpc_pkg::REG_TEMP_COEFFS, {16'd0, t[2], t[1], t[0]});
        put_coeff(bpc_pkg::REG_PRESS_LOW, {p[3], p[2], p[1], p[0]});
        put_coeff(bpc_pkg::REG_PRESS_HIGH, {p[7], p[6], p[5], p[4]});
        put_coeff(bpc_pkg::REG_PRESS_NINE, {48'd0, p[8]});
    endtask

    task automatic new_phase(int kind);
        start <= 1'b0;
        drain();
        repeat (LATENCY + 2) @(posedge clk);
        phases++;
        case (kind)
            0: load_typical(1'b0);
            1: load_typical(1'b1);
            2:
            begin
                put_coeff(bpc_pkg::REG_TEMP_COEFFS, 64'hFFFF_FFFF_FFFF_FFFF);
                put_coeff(bpc_pkg::REG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
                put_coeff(bpc_pkg::REG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
                put_coeff(bpc_pkg::REG_PRESS_NINE, 64'hFFFF_FFFF_FFFF_FFFF);
            end
            3:
            begin
                put_coeff(bpc_pkg::REG_TEMP_COEFFS, 64'h0000_8000_8000_0000);
                put_coeff(bpc_pkg::REG_PRESS_LOW, 64'h8000_8000_8000_0000);
                put_coeff(bpc_pkg::REG_PRESS_HIGH, 64'h8000_8000_8000_8000);
                put_coeff(bpc_pkg::REG_PRESS_NINE, 64'h0000_0000_0000_8000);
            end
            4:
            begin
                put_coeff(bpc_pkg::REG_TEMP_COEFFS, 64'h0000_7FFF_7FFF_FFFF);
                put_coeff(bpc_pkg::REG_PRESS_LOW, 64'h7FFF_7FFF_7FFF_FFFF);
                put_coeff(bpc_pkg::REG_PRESS_HIGH, 64'h7FFF_7FFF_7FFF_7FFF);
                put_coeff(bpc_pkg::REG_PRESS_NINE, 64'h0000_0000_0000_7FFF);
            end
            default:
            begin
                put_coeff(bpc_pkg::REG_TEMP_COEFFS, rand64());
                put_coeff(bpc_pkg::REG_PRESS_LOW, rand64());
                put_coeff(bpc_pkg::REG_PRESS_HIGH, rand64());
                put_coeff(bpc_pkg::REG_PRESS_NINE, rand64());
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [19:0] ap;
        logic [19:0] at;
        int kind;
        rst_n     = 1'b0;
        start     = 1'b0;
        sample    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        sent      = 0;
        phases    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero coefficients after reset: divisor is zero
        send_beat(20'd0, 20'd0, 0);
        send_beat(20'hFFFFF, 20'hFFFFF, 1);
        new_phase(0);
        send_beat(20'd0, 20'd0, 0);
        send_beat(20'hFFFFF, 20'hFFFFF, 0);
        send_beat(20'd0, 20'hFFFFF, 0);
        send_beat(20'hFFFFF, 20'd0, 2);
        send_beat(20'd415148, 20'd519888, 0);
        send_beat(20'h55555, 20'hAAAAA, 0);
        send_beat(20'hAAAAA, 20'h55555, 0);
        // tiny pressure reading drives the wide-numerator division branch
        send_beat(20'd1, 20'd519888, 0);
        new_phase(2);
        send_beat(20'd0, 20'd0, 0);
        send_beat(20'hFFFFF, 20'hFFFFF, 0);
        new_phase(3);
        send_beat(20'd0, 20'hFFFFF, 0);
        send_beat(20'hFFFFF, 20'd0, 0);
        new_phase(4);
        send_beat(20'd0, 20'd0, 0);
        send_beat(20'hFFFFF, 20'hFFFFF, 0);

        while (sent < 570)
        begin
            if ((sent % 60) == 0)
            begin
                kind = $urandom_range(0, 9);
                new_phase(kind < 5 ? 1 : (kind < 9 ? 5 : kind - 9));
            end
            if ($urandom_range(0, 3) == 0)
            begin
                ap = 20'($urandom());
                at = 20'($urandom());
            end
            else
            begin
                ap = 20'($urandom_range(200000, 600000));
                at = 20'($urandom_range(400000, 600000));
            end
            send_beat(ap, at, pick_gap());
        end
        start <= 1'b0;
        drain();
        repeat (LATENCY + 5) @(posedge clk);
        $display("Sent %0d samples across %0d coefficient sets, with random gaps.",
                 sent, phases);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
